[hdl/bresenham_line_stepper_defines.svh]
// Assertion macros shared by the line stepper modules.
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bls_pkg.sv]
// Shared constants, codes and types of the line stepper.
package bls_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int SCALE_W         = 4;
	localparam int OFFSET_W        = 13;
	localparam int PIX_W           = 17;
	localparam int CFG_IDX_W       = 2;
	localparam int MODE_W          = 2;

	// Request opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Walk modes
	localparam logic [MODE_W-1:0] MODE_SHALLOW     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEEP       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHALLOW_NEG = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STEEP_NEG   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd3;

	localparam logic [SCALE_W-1:0]         SCALE_X_RST  = 4'd2;
	localparam logic [SCALE_W-1:0]         SCALE_Y_RST  = 4'd2;
	localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = 13'sd100;
	localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = 13'sd200;

	localparam logic signed [PIX_W-1:0] PIX_MAX = 17'sh0FFFF;
	localparam logic signed [PIX_W-1:0] PIX_MIN = 17'sh10000;

	typedef struct packed {
		logic [SCALE_W-1:0]         scale_x;
		logic [SCALE_W-1:0]         scale_y;
		logic signed [OFFSET_W-1:0] offset_x;
		logic signed [OFFSET_W-1:0] offset_y;
	} cfg_t;

endpackage

[hdl/bls_front.sv]
// Front end: register requests, classify the walk mode, set up the decision terms.
module bls_front #(
	parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   op,
	input  logic signed [COORD_BITS-1:0]           x_start,
	input  logic signed [COORD_BITS-1:0]           y_start,
	input  logic signed [COORD_BITS-1:0]           x_end,
	input  logic signed [COORD_BITS-1:0]           y_end,
	input  logic                                   q_full,
	output logic                                   q_push,
	output logic                                   cmd_op,
	output logic [bls_pkg::MODE_W-1:0]             cmd_mode,
	output logic signed [COORD_BITS:0]             cmd_major,
	output logic signed [COORD_BITS+1:0]           cmd_minor,
	output logic signed [COORD_BITS:0]             cmd_limit,
	output logic signed [COORD_BITS+3:0]           cmd_decision,
	output logic signed [COORD_BITS+3:0]           cmd_diag,
	output logic signed [COORD_BITS+3:0]           cmd_straight
);

	localparam int C  = COORD_BITS;
	localparam int DW = COORD_BITS + 4;

	logic                v_s1, op_s1;
	logic signed [C-1:0] xs_s1, ys_s1, xe_s1, ye_s1;
	logic                v_s2, op_s2;
	logic [bls_pkg::MODE_W-1:0] mode_s2;
	logic signed [C:0]   a0_s2, a1_s2, b0_s2, b1_s2;

	logic ready_s1, ready_s2;

	logic signed [C:0] xs_e, ys_e, xe_e, ye_e, ddx, ddy;
	logic [C:0]        adx, ady;
	logic              pos_x, pos_y;
	logic [bls_pkg::MODE_W-1:0] mode_c;
	logic signed [C:0] a0_c, a1_c, b0_c, b1_c;

	logic              swap;
	logic signed [C:0] lo_a, hi_a, lo_b, hi_b;
	logic signed [C+1:0] dx, dy;
	logic signed [DW-1:0] dx_w, dy_w, dd_w;

	assign ready_s2 = !v_s2 || !q_full;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign q_push   = v_s2 && !q_full;

	// Stage 1 classification
	always_comb begin
		xs_e  = {xs_s1[C-1], xs_s1};
		ys_e  = {ys_s1[C-1], ys_s1};
		xe_e  = {xe_s1[C-1], xe_s1};
		ye_e  = {ye_s1[C-1], ye_s1};
		ddx   = xe_e - xs_e;
		ddy   = ye_e - ys_e;
		adx   = ddx[C] ? -ddx : ddx;
		ady   = ddy[C] ? -ddy : ddy;
		pos_x = !ddx[C] && (ddx != '0);
		pos_y = !ddy[C] && (ddy != '0);
		if (ddx == '0) begin
			mode_c = bls_pkg::MODE_STEEP;
		end else if (ddy == '0) begin
			mode_c = bls_pkg::MODE_SHALLOW;
		end else if (pos_x == pos_y) begin
			mode_c = (ady > adx) ? bls_pkg::MODE_STEEP : bls_pkg::MODE_SHALLOW;
		end else begin
			mode_c = (ady >= adx) ? bls_pkg::MODE_STEEP_NEG : bls_pkg::MODE_SHALLOW_NEG;
		end
		case (mode_c)
			bls_pkg::MODE_SHALLOW: begin
				a0_c = xs_e; b0_c = ys_e; a1_c = xe_e; b1_c = ye_e;
			end
			bls_pkg::MODE_STEEP: begin
				a0_c = ys_e; b0_c = xs_e; a1_c = ye_e; b1_c = xe_e;
			end
			bls_pkg::MODE_SHALLOW_NEG: begin
				a0_c = xs_e; b0_c = -ys_e; a1_c = xe_e; b1_c = -ye_e;
			end
			default: begin
				a0_c = ys_e; b0_c = -xs_e; a1_c = ye_e; b1_c = -xe_e;
			end
		endcase
	end

	// Stage 2 ordering and decision terms
	always_comb begin
		swap = a0_s2 > a1_s2;
		lo_a = swap ? a1_s2 : a0_s2;
		hi_a = swap ? a0_s2 : a1_s2;
		lo_b = swap ? b1_s2 : b0_s2;
		hi_b = swap ? b0_s2 : b1_s2;
		dx   = {hi_a[C], hi_a} - {lo_a[C], lo_a};
		dy   = {hi_b[C], hi_b} - {lo_b[C], lo_b};
		dx_w = {{2{dx[C+1]}}, dx};
		dy_w = {{2{dy[C+1]}}, dy};
		dd_w = dy_w - dx_w;
	end

	assign cmd_op       = op_s2;
	assign cmd_mode     = mode_s2;
	assign cmd_major    = lo_a;
	assign cmd_minor    = {lo_b[C], lo_b};
	assign cmd_limit    = hi_a;
	assign cmd_straight = {dy_w[DW-2:0], 1'b0};
	assign cmd_diag     = {dd_w[DW-2:0], 1'b0};
	assign cmd_decision = {dy_w[DW-2:0], 1'b0} - dx_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			op_s1 <= op;
			xs_s1 <= x_start;
			ys_s1 <= y_start;
			xe_s1 <= x_end;
			ye_s1 <= y_end;
		end
		if (v_s1 && ready_s2) begin
			op_s2   <= op_s1;
			mode_s2 <= mode_c;
			a0_s2   <= a0_c;
			a1_s2   <= a1_c;
			b0_s2   <= b0_c;
			b1_s2   <= b1_c;
		end
	end

endmodule

[hdl/bls_queue.sv]
// Small register queue between the front end and the walker.
`include "bresenham_line_stepper_defines.svh"

module bls_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`BLS_ASSERT_NOW(a_no_push_full, full, !push, "queue written while full")
	`BLS_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue count did not advance")

endmodule

[hdl/bls_back.sv]
// Back end: walk the active segment and emit transformed, saturated pixels.
`include "bresenham_line_stepper_defines.svh"

module bls_back #(
	parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bls_pkg::cfg_t                       cfg,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  logic                                cmd_op,
	input  logic [bls_pkg::MODE_W-1:0]          cmd_mode,
	input  logic signed [COORD_BITS:0]          cmd_major,
	input  logic signed [COORD_BITS+1:0]        cmd_minor,
	input  logic signed [COORD_BITS:0]          cmd_limit,
	input  logic signed [COORD_BITS+3:0]        cmd_decision,
	input  logic signed [COORD_BITS+3:0]        cmd_diag,
	input  logic signed [COORD_BITS+3:0]        cmd_straight,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bls_pkg::PIX_W-1:0]    pixel_x,
	output logic signed [bls_pkg::PIX_W-1:0]    pixel_y,
	output logic                                last_pixel
);

	localparam int C   = COORD_BITS;
	localparam int DW  = COORD_BITS + 4;
	localparam int PXW = COORD_BITS + 3;
	localparam int PRW = PXW + bls_pkg::SCALE_W + 1;
	localparam int SW  = (PRW + 1 > bls_pkg::PIX_W + 1) ? PRW + 1 : bls_pkg::PIX_W + 1;
	localparam logic signed [SW-1:0] SAT_HI = SW'(bls_pkg::PIX_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(bls_pkg::PIX_MIN);

	logic signed [C:0]    major_q, limit_q;
	logic signed [C+1:0]  minor_q;
	logic signed [DW-1:0] dec_q, diag_q, straight_q;
	logic [bls_pkg::MODE_W-1:0] mode_q;
	logic                 active_q, out_valid_q, last_q;
	logic signed [bls_pkg::PIX_W-1:0] pixel_x_q, pixel_y_q;

	logic                 out_free, emit, last_c, dec_pos;
	logic signed [PXW-1:0] major_x, minor_x, px, py;
	logic signed [PRW-1:0] prod_x, prod_y;
	logic signed [SW-1:0]  sum_x, sum_y;

	function automatic logic signed [bls_pkg::PIX_W-1:0] sat_pix(
		input logic signed [SW-1:0] v
	);
		logic signed [bls_pkg::PIX_W-1:0] r;
		if (v > SAT_HI) begin
			r = bls_pkg::PIX_MAX;
		end else if (v < SAT_LO) begin
			r = bls_pkg::PIX_MIN;
		end else begin
			r = v[bls_pkg::PIX_W-1:0];
		end
		return r;
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = q_valid && (cmd_op == bls_pkg::OP_LOAD || !active_q || out_free);
	assign emit     = q_pop && cmd_op == bls_pkg::OP_STEP && active_q;
	assign last_c   = major_q >= limit_q;
	assign dec_pos  = !dec_q[DW-1] && (dec_q != '0);

	// Map the walk frame back to screen axes
	always_comb begin
		major_x = {{2{major_q[C]}}, major_q};
		minor_x = {minor_q[C+1], minor_q};
		case (mode_q)
			bls_pkg::MODE_SHALLOW: begin
				px = major_x; py = minor_x;
			end
			bls_pkg::MODE_STEEP: begin
				px = minor_x; py = major_x;
			end
			bls_pkg::MODE_SHALLOW_NEG: begin
				px = major_x; py = -minor_x;
			end
			default: begin
				px = -minor_x; py = major_x;
			end
		endcase
		prod_x = px * $signed({1'b0, cfg.scale_x});
		prod_y = py * $signed({1'b0, cfg.scale_y});
		sum_x  = $signed({{(SW-PRW){prod_x[PRW-1]}}, prod_x})
			+ $signed({{(SW-bls_pkg::OFFSET_W){cfg.offset_x[bls_pkg::OFFSET_W-1]}}, cfg.offset_x});
		sum_y  = $signed({{(SW-PRW){prod_y[PRW-1]}}, prod_y})
			+ $signed({{(SW-bls_pkg::OFFSET_W){cfg.offset_y[bls_pkg::OFFSET_W-1]}}, cfg.offset_y});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q     <= '0;
			minor_q     <= '0;
			limit_q     <= '0;
			dec_q       <= '0;
			diag_q      <= '0;
			straight_q  <= '0;
			mode_q      <= bls_pkg::MODE_SHALLOW;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && cmd_op == bls_pkg::OP_LOAD) begin
				major_q    <= cmd_major;
				minor_q    <= cmd_minor;
				limit_q    <= cmd_limit;
				dec_q      <= cmd_decision;
				diag_q     <= cmd_diag;
				straight_q <= cmd_straight;
				mode_q     <= cmd_mode;
				active_q   <= 1'b1;
			end else if (emit) begin
				if (dec_pos) begin
					minor_q <= minor_q + 1'b1;
					dec_q   <= dec_q + diag_q;
				end else begin
					dec_q   <= dec_q + straight_q;
				end
				major_q <= major_q + 1'b1;
				if (last_c) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q <= sat_pix(sum_x);
			pixel_y_q <= sat_pix(sum_y);
			last_q    <= last_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_q;

	`BLS_ASSERT_NEXT(a_last_ends, emit && last_c, !active_q, "segment still active after last pixel")
	`BLS_ASSERT_NEXT(a_load_arms, q_pop && cmd_op == bls_pkg::OP_LOAD, active_q, "load did not arm segment")

endmodule

[hdl/bresenham_line_stepper.sv]
// A step request passes the two front-end stages and the queue; the walker registers its pixel onto out_valid.
// Throughput: one request per clock; the walker retires one each cycle unless the output stalls.
// Load requests give no pixel; steps with no active segment give no pixel.
// Stalls on the output side back up through a four-entry request queue.
// Reset (arst_n low, asynchronous) clears the pipeline, the queue and the walker,
// and restores scale 2,2 and offset 100,200.
module bresenham_line_stepper #(
	parameter int COORD_BITS  = bls_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bls_pkg::OFFSET_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic signed [COORD_BITS-1:0]        x_start,
	input  logic signed [COORD_BITS-1:0]        y_start,
	input  logic signed [COORD_BITS-1:0]        x_end,
	input  logic signed [COORD_BITS-1:0]        y_end,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bls_pkg::PIX_W-1:0]    pixel_x,
	output logic signed [bls_pkg::PIX_W-1:0]    pixel_y,
	output logic                                last_pixel
);

	localparam int C  = COORD_BITS;
	localparam int DW = COORD_BITS + 4;
	localparam int MW = bls_pkg::MODE_W;
	// Queue entry: op, mode, major, minor, limit, decision, diagonal, straight
	localparam int QW = 1 + MW + (C + 1) + (C + 2) + (C + 1) + 3 * DW;

	bls_pkg::cfg_t cfg_q;

	// Front-end request, already classified
	logic                 f_push, q_full, q_not_empty, q_pop;
	logic                 f_op, b_op;
	logic [MW-1:0]        f_mode, b_mode;
	logic signed [C:0]    f_major, f_limit, b_major, b_limit;
	logic signed [C+1:0]  f_minor, b_minor;
	logic signed [DW-1:0] f_dec, f_diag, f_str, b_dec, b_diag, b_str;
	logic [QW-1:0]        q_wdata, q_rdata;

	// Configuration registers; the user must write them only while the block is idle (not enforced by the block)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_x  <= bls_pkg::SCALE_X_RST;
			cfg_q.scale_y  <= bls_pkg::SCALE_Y_RST;
			cfg_q.offset_x <= bls_pkg::OFFSET_X_RST;
			cfg_q.offset_y <= bls_pkg::OFFSET_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bls_pkg::CFG_SCALE_X:  cfg_q.scale_x  <= cfg_data[bls_pkg::SCALE_W-1:0];
				bls_pkg::CFG_SCALE_Y:  cfg_q.scale_y  <= cfg_data[bls_pkg::SCALE_W-1:0];
				bls_pkg::CFG_OFFSET_X: cfg_q.offset_x <= cfg_data;
				bls_pkg::CFG_OFFSET_Y: cfg_q.offset_y <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: two stages, classify the octant then order endpoints and
	// build the Bresenham increments. It stalls only when the queue is full.
	bls_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.q_full      (q_full),
		.q_push      (f_push),
		.cmd_op      (f_op),
		.cmd_mode    (f_mode),
		.cmd_major   (f_major),
		.cmd_minor   (f_minor),
		.cmd_limit   (f_limit),
		.cmd_decision(f_dec),
		.cmd_diag    (f_diag),
		.cmd_straight(f_str)
	);

	assign q_wdata = {f_op, f_mode, f_major, f_minor, f_limit, f_dec, f_diag, f_str};

	// Queue decouples classification from the walker so either side can hold
	bls_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.rdata    (q_rdata)
	);

	assign {b_op, b_mode, b_major, b_minor, b_limit, b_dec, b_diag, b_str} = q_rdata;

	// Back end: loads replace the segment, steps on an active segment emit one pixel and advance
	bls_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_not_empty),
		.q_pop       (q_pop),
		.cmd_op      (b_op),
		.cmd_mode    (b_mode),
		.cmd_major   (b_major),
		.cmd_minor   (b_minor),
		.cmd_limit   (b_limit),
		.cmd_decision(b_dec),
		.cmd_diag    (b_diag),
		.cmd_straight(b_str),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_pixel  (last_pixel)
	);

endmodule
